// ===== rtl/tsd_pkg.sv =====
`timescale 1ns / 1ps

package tsd_pkg;

   // panel defaults
   localparam int PANEL_WIDTH_DEF  = 172;
   localparam int PANEL_HEIGHT_DEF = 320;

   // field widths
   localparam int TIME_W  = 32;
   localparam int RAW_W   = 12;
   localparam int COORD_W = 9;
   localparam int GEST_W  = 8;
   localparam int CNT_W   = 4;
   localparam int DEB_W   = 8;

   localparam int REQ_W  = 72;
   localparam int RSP_W  = 24;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [RAW_W-1:0]  RAW_INVALID = 12'hFFF;
   localparam logic [GEST_W-1:0] GEST_LEFT   = 8'h03;
   localparam logic [GEST_W-1:0] GEST_RIGHT  = 8'h04;

   // register map, word index
   localparam logic [1:0] REG_TOUCH_PRESENT   = 2'd0;
   localparam logic [1:0] REG_INT_DEBOUNCE_MS = 2'd1;
   localparam logic [1:0] REG_SWIPE_MIN_PX    = 2'd2;

   localparam logic [DEB_W-1:0]   DEBOUNCE_RESET  = 8'd2;
   localparam logic [COORD_W-1:0] SWIPE_MIN_RESET = 9'd18;

   typedef struct packed {
      logic [RAW_W-1:0]  raw_y;
      logic [RAW_W-1:0]  raw_x;
      logic [CNT_W-1:0]  n_points;
      logic [GEST_W-1:0] gesture_code;
      logic              frame_ok;
      logic              int_low;
      logic [TIME_W-1:0] now_ms;
      logic              ack_prev;
      logic              ack_next;
   } req_word_type;

   typedef struct packed {
      logic [RSP_W-22:0]  pad;
      logic               swipe_prev;
      logic               swipe_next;
      logic [COORD_W-1:0] touch_y;
      logic [COORD_W-1:0] touch_x;
      logic               touch_active;
   } rsp_word_type;

endpackage

// ===== rtl/touch_swipe_detector_core.sv =====
`timescale 1ns / 1ps

// Channel  | Ports             | Word
// ---------+-------------------+---------------------------------------------
// request  | req_t*            | one poll of the touch controller, 72 bits
// response | rsp_t*            | touch state and pending swipe flags, 24 bits
// control  | csr_p*            | touch_present, int_debounce_ms, swipe_min_px
//
// One poll every cycle unless the response stalls; each poll gives one response,
// passing the input register, then the result register, which also updates the
// touch state. Synchronous active-high reset clears the touch state and loads the
// register defaults. A stalled response holds both stages; the request side
// stalls only when both are full.

module touch_swipe_detector_core
   import tsd_pkg::*;
#(
   parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // ack_next, ack_prev, now_ms[31:0], int_low, frame_ok, gesture_code[7:0],
   // n_points[3:0], raw_x[11:0], raw_y[11:0]
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // touch_active, touch_x[8:0], touch_y[8:0], swipe_next, swipe_prev, zeros
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam logic [RAW_W-1:0] X_LIM = RAW_W'(PANEL_WIDTH - 1);
   localparam logic [RAW_W-1:0] Y_LIM = RAW_W'(PANEL_HEIGHT - 1);

   // configuration
   logic               present_ff;
   logic [DEB_W-1:0]   debounce_ff;
   logic [COORD_W-1:0] swipe_min_ff;
   logic               csr_wr;

   // stages
   logic               s1_valid_ff;
   req_word_type       s1_word_ff;
   logic               out_valid_ff;
   rsp_word_type       out_word_ff, out_word_in;
   logic               out_take, s1_take;

   // touch state
   logic               pressed_ff, pressed_in;
   logic               active_ff, active_in;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_W-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic               low_seen_ff, low_seen_in;
   logic [TIME_W-1:0]  low_start_ff, low_start_in;
   logic               next_ff, next_in, prev_ff, prev_in;

   // datapath
   logic [RAW_W-1:0]   clamp_x, clamp_y;
   logic [COORD_W-1:0] map_x, map_y;
   logic               point_ok, go;
   logic [TIME_W-1:0]  elapsed;
   logic [COORD_W:0]   dx, dy, abs_dx, abs_dy;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= 1'b0;
         debounce_ff  <= DEBOUNCE_RESET;
         swipe_min_ff <= SWIPE_MIN_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_TOUCH_PRESENT:   present_ff   <= csr_pwdata[0];
            REG_INT_DEBOUNCE_MS: debounce_ff  <= csr_pwdata[DEB_W-1:0];
            REG_SWIPE_MIN_PX:    swipe_min_ff <= csr_pwdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_TOUCH_PRESENT:   csr_prdata = {{(CSR_DW-1){1'b0}}, present_ff};
         REG_INT_DEBOUNCE_MS: csr_prdata = {{(CSR_DW-DEB_W){1'b0}}, debounce_ff};
         REG_SWIPE_MIN_PX:    csr_prdata = {{(CSR_DW-COORD_W){1'b0}}, swipe_min_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ handshakes
   assign out_take   = ~out_valid_ff | rsp_tready;
   assign s1_take    = s1_valid_ff & out_take;
   assign req_tready = ~s1_valid_ff | out_take;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) s1_valid_ff  <= req_tvalid;
         if (out_take)   out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) s1_word_ff  <= req_word_type'(req_tdata);
      if (s1_take)                  out_word_ff <= out_word_in;
   end

   // ------------------------------------------------------------ poll logic
   assign clamp_x  = (s1_word_ff.raw_x >= X_LIM) ? X_LIM : s1_word_ff.raw_x;
   assign clamp_y  = (s1_word_ff.raw_y >= Y_LIM) ? Y_LIM : s1_word_ff.raw_y;
   assign map_x    = COORD_W'(X_LIM - clamp_x);
   assign map_y    = COORD_W'(clamp_y);
   assign point_ok = (s1_word_ff.n_points != '0) &&
                     (s1_word_ff.raw_x != RAW_INVALID) &&
                     (s1_word_ff.raw_y != RAW_INVALID);

   // travel since press start, from the held point
   assign dx     = {1'b0, cur_x_ff} - {1'b0, start_x_ff};
   assign dy     = {1'b0, cur_y_ff} - {1'b0, start_y_ff};
   assign abs_dx = dx[COORD_W] ? -dx : dx;
   assign abs_dy = dy[COORD_W] ? -dy : dy;

   always_comb begin
      pressed_in   = pressed_ff;
      active_in    = active_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      low_seen_in  = low_seen_ff;
      low_start_in = low_start_ff;
      next_in      = next_ff & ~s1_word_ff.ack_next;
      prev_in      = prev_ff & ~s1_word_ff.ack_prev;
      go           = 1'b0;
      elapsed      = s1_word_ff.now_ms - (low_seen_ff ? low_start_ff : s1_word_ff.now_ms);

      if (present_ff) begin
         if (!s1_word_ff.int_low && !pressed_ff) begin
            active_in = 1'b0;
         end else begin
            go = 1'b1;
            if (s1_word_ff.int_low && !pressed_ff) begin
               if (!low_seen_ff) begin
                  low_seen_in  = 1'b1;
                  low_start_in = s1_word_ff.now_ms;
               end
               if (elapsed < {{(TIME_W-DEB_W){1'b0}}, debounce_ff}) go = 1'b0;
            end else if (!s1_word_ff.int_low) begin
               low_seen_in  = 1'b0;
               low_start_in = '0;
            end
         end
      end

      if (go && s1_word_ff.frame_ok) begin
         if (point_ok) begin
            active_in = 1'b1;
            cur_x_in  = map_x;
            cur_y_in  = map_y;
            if (!pressed_ff) begin
               pressed_in = 1'b1;
               start_x_in = map_x;
               start_y_in = map_y;
            end
         end else begin
            active_in = 1'b0;
            if (pressed_ff) begin
               pressed_in = 1'b0;
               if (s1_word_ff.gesture_code == GEST_LEFT) begin
                  next_in = 1'b1;
               end else if (s1_word_ff.gesture_code == GEST_RIGHT) begin
                  prev_in = 1'b1;
               end
               // classify only when no swipe is already pending
               if (!next_in && !prev_in &&
                   abs_dx >= {1'b0, swipe_min_ff} && abs_dy <= abs_dx) begin
                  if (dx[COORD_W]) next_in = 1'b1;
                  else             prev_in = 1'b1;
               end
            end
         end
      end

      out_word_in              = '0;
      out_word_in.touch_active = active_in;
      out_word_in.touch_x      = cur_x_in;
      out_word_in.touch_y      = cur_y_in;
      out_word_in.swipe_next   = next_in;
      out_word_in.swipe_prev   = prev_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff   <= 1'b0;
         active_ff    <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         low_seen_ff  <= 1'b0;
         low_start_ff <= '0;
         next_ff      <= 1'b0;
         prev_ff      <= 1'b0;
      end else if (s1_take) begin
         pressed_ff   <= pressed_in;
         active_ff    <= active_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         low_seen_ff  <= low_seen_in;
         low_start_ff <= low_start_in;
         next_ff      <= next_in;
         prev_ff      <= prev_in;
      end
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import tsd_pkg::*;

   localparam int PANEL_W     = PANEL_WIDTH_DEF;
   localparam int PANEL_H     = PANEL_HEIGHT_DEF;
   localparam int CYCLE_LIMIT = 600000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   touch_swipe_detector_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // register copies seen by the touch tracker
   logic               cfg_present   = 1'b0;
   logic [DEB_W-1:0]   cfg_debounce  = DEBOUNCE_RESET;
   logic [COORD_W-1:0] cfg_swipe_min = SWIPE_MIN_RESET;

   // touch tracker state
   logic               press_held    = 1'b0;
   logic               point_live    = 1'b0;
   logic [COORD_W-1:0] pos_x         = '0;
   logic [COORD_W-1:0] pos_y         = '0;
   logic [COORD_W-1:0] origin_x      = '0;
   logic [COORD_W-1:0] origin_y      = '0;
   logic               line_low_seen = 1'b0;
   logic [TIME_W-1:0]  line_low_t0   = '0;
   logic               page_next     = 1'b0;
   logic               page_prev     = 1'b0;

   req_word_type poll_q[$];
   rsp_word_type touch_due[$];

   logic [TIME_W-1:0] stamp_ms = 32'd100;
   int polls_made = 0;
   int err_count = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int req_calm = 0;
   int stall_left = 0;
   int rsp_calm = 0;
   bit rsp_hold_req = 1'b0;

   task automatic note_error(input string what, input longint got, input longint want);
      err_count++;
      if (err_count <= 10)
         $display("mismatch %s: got %0d, expected %0d", what, got, want);
   endtask

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // advance the touch state by one poll
   function automatic void advance_touch(input req_word_type p);
      logic [TIME_W-1:0] held_ms;
      int rx, ry, dx, dy, adx, ady;
      if (p.ack_next) page_next = 1'b0;
      if (p.ack_prev) page_prev = 1'b0;
      if (!cfg_present) return;
      if (!p.int_low && !press_held) begin
         point_live = 1'b0;
         return;
      end
      if (p.int_low && !press_held) begin
         if (!line_low_seen) begin
            line_low_seen = 1'b1;
            line_low_t0 = p.now_ms;
         end
         held_ms = p.now_ms - line_low_t0;
         if (held_ms < TIME_W'(cfg_debounce)) return;
      end else if (!p.int_low) begin
         line_low_seen = 1'b0;
         line_low_t0 = '0;
      end
      if (!p.frame_ok) return;
      if (p.n_points != 0 && p.raw_x != RAW_INVALID && p.raw_y != RAW_INVALID) begin
         rx = int'(p.raw_x);
         ry = int'(p.raw_y);
         if (rx > PANEL_W - 1) rx = PANEL_W - 1;
         if (ry > PANEL_H - 1) ry = PANEL_H - 1;
         point_live = 1'b1;
         pos_x = COORD_W'(PANEL_W - 1 - rx);
         pos_y = COORD_W'(ry);
         if (!press_held) begin
            press_held = 1'b1;
            origin_x = pos_x;
            origin_y = pos_y;
         end
         return;
      end
      point_live = 1'b0;
      if (!press_held) return;
      if (p.gesture_code == GEST_LEFT) page_next = 1'b1;
      else if (p.gesture_code == GEST_RIGHT) page_prev = 1'b1;
      // classify the travel only when no swipe is pending
      if (!page_next && !page_prev) begin
         dx = int'(pos_x) - int'(origin_x);
         dy = int'(pos_y) - int'(origin_y);
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         if (adx >= int'(cfg_swipe_min) && ady <= adx) begin
            if (dx < 0) page_next = 1'b1;
            else page_prev = 1'b1;
         end
      end
      press_held = 1'b0;
   endfunction

   function automatic rsp_word_type touch_report();
      rsp_word_type r;
      r = '0;
      r.touch_active = point_live;
      r.touch_x = pos_x;
      r.touch_y = pos_y;
      r.swipe_next = page_next;
      r.swipe_prev = page_prev;
      return r;
   endfunction

   // poll driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_touch(req_word_type'(req_tdata));
            touch_due.push_back(touch_report());
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (poll_q.size() != 0) begin
               req_tdata <= poll_q.pop_front();
               req_tvalid <= 1'b1;
               if (req_calm > 0) begin
                  req_calm--;
               end else if ($urandom_range(0, 49) == 0) begin
                  req_calm = $urandom_range(20, 80);
               end else begin
                  gap_left = draw_gap();
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and ready pattern
   always @(posedge clock) begin
      rsp_word_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'(rsp_tdata);
            if (touch_due.size() == 0) begin
               note_error("result with nothing pending", got, 0);
            end else begin
               want = touch_due.pop_front();
               if (got.touch_active != want.touch_active)
                  note_error("touch_active", got.touch_active, want.touch_active);
               if (got.touch_x != want.touch_x)
                  note_error("touch_x", got.touch_x, want.touch_x);
               if (got.touch_y != want.touch_y)
                  note_error("touch_y", got.touch_y, want.touch_y);
               if (got.swipe_next != want.swipe_next)
                  note_error("swipe_next", got.swipe_next, want.swipe_next);
               if (got.swipe_prev != want.swipe_prev)
                  note_error("swipe_prev", got.swipe_prev, want.swipe_prev);
            end
         end
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_calm > 0) rsp_calm--;
            else if ($urandom_range(0, 49) == 0) rsp_calm = $urandom_range(20, 80);
            else if ($urandom_range(0, 2) == 0) stall_left = draw_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DW-1:0] val);
      logic [CSR_DW-1:0] got;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got != val) note_error("register readback", got, val);
      case (idx)
         REG_TOUCH_PRESENT:   cfg_present = val[0];
         REG_INT_DEBOUNCE_MS: cfg_debounce = val[DEB_W-1:0];
         REG_SWIPE_MIN_PX:    cfg_swipe_min = val[COORD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(input bit pres, input int deb, input int smin);
      csr_write(REG_TOUCH_PRESENT, CSR_DW'(pres));
      csr_write(REG_INT_DEBOUNCE_MS, CSR_DW'(deb));
      csr_write(REG_SWIPE_MIN_PX, CSR_DW'(smin));
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (poll_q.size() != 0 || req_tvalid || touch_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_poll(input bit an, input bit ap, input int adv, input bit il,
                           input bit fok, input logic [GEST_W-1:0] g, input int cnt,
                           input int rx, input int ry);
      req_word_type w;
      stamp_ms = stamp_ms + TIME_W'(adv);
      w.ack_next = an;
      w.ack_prev = ap;
      w.now_ms = stamp_ms;
      w.int_low = il;
      w.frame_ok = fok;
      w.gesture_code = g;
      w.n_points = CNT_W'(cnt);
      w.raw_x = RAW_W'(rx);
      w.raw_y = RAW_W'(ry);
      poll_q.push_back(w);
      polls_made++;
   endtask

   function automatic bit rand_ack();
      return $urandom_range(0, 4) == 0;
   endfunction

   function automatic int clamp_raw(input int v);
      if (v < 0) return 0;
      if (v > 4094) return 4094;
      return v;
   endfunction

   function automatic logic [GEST_W-1:0] pick_gesture();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return 8'h00;
      if (r < 6) return GEST_LEFT;
      if (r < 8) return GEST_RIGHT;
      return GEST_W'($urandom_range(0, 255));
   endfunction

   task automatic add_noise();
      if ($urandom_range(0, 19) == 0) stamp_ms = $urandom;
      add_poll(rand_ack(), rand_ack(), $urandom_range(0, 300), $urandom_range(0, 1),
               $urandom_range(0, 1), GEST_W'($urandom_range(0, 255)),
               $urandom_range(0, 15), $urandom_range(0, 4095), $urandom_range(0, 4095));
   endtask

   // one press: a few idle polls, a moving point, then a release
   task automatic add_swipe();
      int x0, y0, dx_end, dy_end, n_move, k, pace, kind, cnt, rx, ry;
      pace = int'(cfg_debounce) / 3 + 2;
      repeat ($urandom_range(0, 2))
         add_poll(rand_ack(), rand_ack(), $urandom_range(1, 30), 1'b0, $urandom_range(0, 1),
                  GEST_W'($urandom_range(0, 255)), $urandom_range(0, 15),
                  $urandom_range(0, 4095), $urandom_range(0, 4095));
      x0 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4094) : $urandom_range(0, 190);
      y0 = $urandom_range(0, 340);
      dx_end = $urandom_range(0, 360) - 180;
      dy_end = $urandom_range(0, 160) - 80;
      n_move = $urandom_range(2, 8);
      for (k = 0; k < n_move; k++) begin
         add_poll(rand_ack(), rand_ack(), $urandom_range(0, pace), 1'b1,
                  $urandom_range(0, 9) != 0,
                  ($urandom_range(0, 3) == 0) ? GEST_W'($urandom_range(0, 255)) : 8'h00,
                  $urandom_range(1, 15),
                  clamp_raw(x0 + dx_end * k / (n_move - 1)),
                  clamp_raw(y0 + dy_end * k / (n_move - 1)));
      end
      kind = $urandom_range(0, 3);
      cnt = (kind == 0) ? 0 : $urandom_range(1, 15);
      rx = (kind == 1 || kind == 3) ? 4095 : $urandom_range(0, 4095);
      ry = (kind == 2 || kind == 3) ? 4095 : $urandom_range(0, 4095);
      if (kind == 3) cnt = $urandom_range(0, 15);
      add_poll(rand_ack(), rand_ack(), $urandom_range(0, pace), $urandom_range(0, 1),
               $urandom_range(0, 7) != 0, pick_gesture(), cnt, rx, ry);
   endtask

   task automatic run_phase(input int n_polls, input bit hold_rsp);
      int goal;
      goal = polls_made + n_polls;
      if ($urandom_range(0, 4) == 0) stamp_ms = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
      while (polls_made < goal) begin
         if ($urandom_range(0, 4) == 0) add_noise();
         else add_swipe();
      end
      // stall the result side while the queue is full of polls
      if (hold_rsp) rsp_hold_req = 1'b1;
      wait_idle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // controller absent: only the acks act
      add_poll(1, 1, 0, 1, 1, 8'h00, 1, 50, 60);
      add_poll(0, 0, 5, 1, 1, GEST_LEFT, 0, 4095, 4095);
      wait_idle();
      csr_write(REG_TOUCH_PRESENT, 32'd1);

      add_poll(0, 0, 1, 0, 1, 8'h00, 1, 10, 10);        // idle line
      add_poll(0, 0, 1, 1, 1, 8'h00, 1, 10, 10);        // latch the low start
      add_poll(0, 0, 1, 1, 1, 8'h00, 1, 10, 10);        // still debouncing
      add_poll(0, 0, 1, 1, 0, 8'h00, 1, 10, 10);        // failed frame
      add_poll(0, 0, 1, 1, 1, 8'h00, 1, 0, 0);
      add_poll(0, 0, 1, 1, 1, 8'h00, 15, 4094, 4094);   // clamp at both edges
      add_poll(0, 0, 1, 1, 1, 8'h00, 1, 4094, 0);
      add_poll(0, 0, 1, 1, 1, 8'h00, 0, 0, 0);          // release, left travel
      add_poll(1, 0, 1, 1, 1, 8'h00, 1, 100, 100);
      add_poll(0, 0, 1, 1, 1, 8'h00, 1, 110, 100);
      add_poll(0, 0, 1, 0, 1, GEST_RIGHT, 1, 4095, 50); // line high while held
      add_poll(0, 0, 1, 1, 1, 8'h00, 1, 80, 80);
      add_poll(0, 0, 2, 1, 1, 8'h00, 1, 80, 80);
      add_poll(0, 0, 1, 1, 1, 8'h00, 1, 0, 80);
      add_poll(0, 0, 1, 1, 1, GEST_LEFT, 1, 20, 4095);  // release with a flag pending
      add_poll(1, 1, 1, 0, 0, 8'h00, 0, 0, 0);
      // debounce across the time stamp wrap
      stamp_ms = 32'hFFFF_FFFE;
      add_poll(0, 0, 1, 1, 1, 8'hFF, 1, 150, 300);
      add_poll(0, 0, 1, 1, 1, 8'hFF, 1, 150, 300);
      add_poll(0, 0, 1, 1, 1, 8'h00, 1, 150, 300);
      add_poll(0, 0, 1, 1, 1, 8'h00, 2, 140, 280);
      add_poll(0, 0, 1, 1, 1, 8'hFF, 0, 140, 280);      // short travel, odd code
      add_poll(0, 0, 1, 1, 1, 8'h00, 1, 100, 100);
      add_poll(0, 0, 1, 1, 1, 8'h00, 1, 140, 140);      // equal dx and dy
      add_poll(0, 0, 1, 0, 1, 8'h00, 0, 0, 0);
      add_poll(0, 0, 1, 0, 0, 8'h00, 0, 0, 0);
      wait_idle();

      set_regs(1, 2, 18);
      run_phase(200, 1);
      set_regs(1, 0, 0);
      run_phase(170, 0);
      set_regs(1, 255, 511);
      run_phase(170, 0);
      set_regs(0, 7, 40);
      run_phase(100, 0);
      set_regs(1, 255, 0);
      run_phase(170, 0);
      set_regs(1, 0, 511);
      run_phase(170, 0);
      repeat (2) begin
         set_regs(1, $urandom_range(0, 40), $urandom_range(0, 120));
         run_phase(170, 0);
      end

      repeat (10) @(posedge clock);
      if (err_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tsd_pkg.sv
rtl/touch_swipe_detector_core.sv
dv/testbench.sv
